// ===== rtl/lcma_pkg.sv =====
// Shared types and constants for the load-cell moving average block.
// No dependencies; imported by load_cell_moving_average and lcma_checker.
`default_nettype none

package lcma_pkg;

  // Field widths
  localparam int unsigned CAL_W  = 24;  // calibration, Q.8 counts per gram
  localparam int unsigned RD_W   = 25;  // signed converter reading
  localparam int unsigned GRAM_W = 32;  // signed grams, Q.8
  localparam int unsigned SUM_W  = 38;  // signed running sum of the ring
  localparam int unsigned FILL_W = 7;   // fill count, 0..DEPTH
  localparam int unsigned FRAC_W = 16;  // reading is scaled by 2^16 before the divide

  // Serial divider operand widths: |reading| << 16 is the widest dividend
  localparam int unsigned NUM_W = RD_W + FRAC_W;
  localparam int unsigned DEN_W = CAL_W;

  // Stream word widths
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = GRAM_W + RD_W + FILL_W;

  // Register file
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic [PADDR_W-1:0] REG_CAL_ADDR = 3'h0;
  localparam logic [CAL_W-1:0]   CAL_RESET    = 24'd256;

  // Commands carried in tuser
  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_TARE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a word
    ST_RD,      // ring read data valid, take the oldest entry off the sum
    ST_GDIV,    // counts to grams division running
    ST_ACC,     // add new gram value to the sum, advance pointer and count
    ST_MSTART,  // launch the mean division
    ST_MDIV,    // mean division running
    ST_FIN      // result ready for the output register
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/lcma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module lcma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcma_div.sv =====
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// No package dependency; widths come from the instantiating module.
`default_nettype none

module lcma_div #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire [NUM_W-1:0]   num_i,
  input  wire [DEN_W-1:0]   den_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;

  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/load_cell_moving_average.sv =====
// A reading word passes through the counts-to-grams divide and then the mean divide
// before its result is registered; a tare word clears the ring state and goes
// straight on to the result. One bit-serial divider is shared by both divides, so a
// new word is taken only once the last one is through. The output register lets the
// next word be taken while a result still waits. rst_ni is asynchronous, active low:
// it clears sum, count, pointer, held reading and smoothed value, and loads 256.
`default_nettype none

module load_cell_moving_average
  import lcma_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input stream
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [S_DATA_W-1:0]    s_axis_tdata,   // [24:0] reading, [31:25] zero
  input  wire                   s_axis_tuser,   // [0] cmd
  // result stream
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata,   // [31:0] smoothed_grams,
                                                // [56:32] last_reading, [63:57] filled
  // register port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [PADDR_W-1:0]     paddr,
  input  wire [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  // state
  state_e               state_q, state_d;
  logic [CAL_W-1:0]     cal_q;
  logic signed [RD_W-1:0]   held_q, held_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [PTR_W-1:0]     pos_q, pos_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [GRAM_W-1:0]    smooth_q, smooth_d;
  logic [GRAM_W-1:0]    gram_q, gram_d;
  logic                 neg_q, neg_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0]  m_data_q, m_data_d;

  // divider and ring
  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [DEN_W-1:0]     div_den;
  logic                 ram_we, ram_re;
  logic [GRAM_W-1:0]    ram_rdata;

  logic signed [RD_W-1:0]  rd_in;
  logic [RD_W-1:0]         rd_abs;
  logic [SUM_W-1:0]        sum_abs;
  logic [GRAM_W-1:0]       ring_old, gram_sat;
  logic                    ring_full, accept, cal_wr;

  // register port
  assign pready = 1'b1;
  assign cal_wr = psel && penable && pwrite && (paddr == REG_CAL_ADDR);
  assign prdata = (paddr == REG_CAL_ADDR) ? PDATA_W'(cal_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CAL_RESET;
    end else if (cal_wr) begin
      cal_q <= pwdata[CAL_W-1:0];
    end
  end

  // operand preparation
  assign rd_in     = s_axis_tdata[RD_W-1:0];
  assign rd_abs    = rd_in[RD_W-1] ? RD_W'(-rd_in) : RD_W'(rd_in);
  assign sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign ring_full = (fill_q == FILL_W'(DEPTH));
  // an entry is only live once the ring has wrapped since the last tare
  assign ring_old  = ring_full ? ram_rdata : '0;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // saturate the gram quotient to signed 32 bits
  always_comb begin
    if (!neg_q) begin
      gram_sat = (div_quo[NUM_W-1:GRAM_W-1] != '0) ? {1'b0, {(GRAM_W-1){1'b1}}}
                                                    : div_quo[GRAM_W-1:0];
    end else if ((div_quo[NUM_W-1:GRAM_W] != '0) ||
                 (div_quo[GRAM_W-1] && (div_quo[GRAM_W-2:0] != '0))) begin
      gram_sat = {1'b1, {(GRAM_W-1){1'b0}}};
    end else begin
      gram_sat = GRAM_W'(-div_quo[GRAM_W-1:0]);
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    sum_d     = sum_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    smooth_d  = smooth_q;
    gram_d    = gram_q;
    neg_d     = neg_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    div_start = 1'b0;
    div_num   = {FRAC_W'(0), rd_abs} << FRAC_W;
    div_den   = (cal_q == '0) ? DEN_W'(1) : cal_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    // output register drains independently
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == CMD_TARE) begin
            sum_d    = '0;
            pos_d    = '0;
            fill_d   = '0;
            smooth_d = '0;
            state_d  = ST_FIN;
          end else begin
            held_d    = rd_in;
            neg_d     = rd_in[RD_W-1];
            div_start = 1'b1;
            ram_re    = 1'b1;
            state_d   = ST_RD;
          end
        end
      end
      ST_RD: begin
        sum_d   = sum_q - SUM_W'($signed(ring_old));
        state_d = ST_GDIV;
      end
      ST_GDIV: begin
        if (div_done) begin
          gram_d  = gram_sat;
          ram_we  = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d   = sum_q + SUM_W'($signed(gram_q));
        pos_d   = (pos_q == PTR_W'(DEPTH - 1)) ? '0 : pos_q + PTR_W'(1);
        fill_d  = ring_full ? fill_q : fill_q + FILL_W'(1);
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sum_abs);
        div_den   = DEN_W'(fill_q);
        neg_d     = sum_q[SUM_W-1];
        state_d   = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_done) begin
          smooth_d = neg_q ? GRAM_W'(-div_quo[GRAM_W-1:0]) : div_quo[GRAM_W-1:0];
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {fill_q, held_q, smooth_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and smoother state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      sum_q     <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
      smooth_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      sum_q     <= sum_d;
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      smooth_q  <= smooth_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    gram_q   <= gram_d;
    neg_q    <= neg_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // shared serial divider
  lcma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // gram ring
  lcma_ram #(
    .WIDTH (GRAM_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (gram_sat),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/lcma_checker.sv =====
// Port-level checks for load_cell_moving_average, attached with a bind.
// Depends on lcma_pkg for field widths.
`default_nettype none

module lcma_checker
  import lcma_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [M_DATA_W-1:0]   m_axis_tdata,
  input wire                  psel,
  input wire                  pready
);

  localparam int unsigned FILL_LSB = GRAM_W + RD_W;

  logic [FILL_W-1:0] out_fill;
  logic [GRAM_W-1:0] out_mean;

  assign out_fill = m_axis_tdata[FILL_LSB +: FILL_W];
  assign out_mean = m_axis_tdata[GRAM_W-1:0];

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // the fill count never passes the ring depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_fill <= FILL_W'(DEPTH))
    else $error("fill count above ring depth");

  // an empty ring always reports a zero mean
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_fill == '0) |-> (out_mean == '0))
    else $error("non-zero mean with empty ring");

  // the block works on one word at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while busy");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low during an access");

endmodule

bind load_cell_moving_average lcma_checker #(.DEPTH(DEPTH)) u_lcma_checker (.*);

`default_nettype wire
